### hw/rtl/vss_pkg.sv
package vss_pkg;

	localparam int SCALE_W   = 10;
	localparam int REFRESH_W = 8;
	localparam int CHAN_W    = 3;
	localparam int VALUE_W   = 10;
	localparam int DIGIT_W   = 4;
	localparam int SEG_W     = 8;
	localparam int EN_W      = 4;
	localparam int CFG_ADDR_W = 2;
	localparam int OUT_DATA_W = 16;

	localparam logic [CFG_ADDR_W-1:0] CFG_REFRESH    = 2'd0;
	localparam logic [CFG_ADDR_W-1:0] CFG_MONITOR    = 2'd1;
	localparam logic [CFG_ADDR_W-1:0] CFG_FULL_SCALE = 2'd2;

	localparam logic OP_TICK   = 1'b0;
	localparam logic OP_SAMPLE = 1'b1;

	localparam logic [1:0] SCAN_SYMBOL   = 2'd0;
	localparam logic [1:0] SCAN_UNITS    = 2'd1;
	localparam logic [1:0] SCAN_TENS     = 2'd2;
	localparam logic [1:0] SCAN_HUNDREDS = 2'd3;

	localparam logic [REFRESH_W-1:0] REFRESH_RST = 8'd10;
	localparam logic [CHAN_W-1:0]    MONITOR_RST = 3'd5;
	localparam logic [SCALE_W-1:0]   SCALE_RST   = 10'd500;

	localparam logic [VALUE_W-1:0] VALUE_MAX = 10'd999;

	localparam logic [SEG_W-1:0] SEG_SYMBOL_V = 8'h3E;
	localparam logic [SEG_W-1:0] SEG_DP       = 8'h80;

	typedef struct packed {
		logic              op;
		logic              refresh;
		logic [1:0]        scan;
		logic [CHAN_W-1:0] chan;
	} ctl_t;

	function automatic logic [SEG_W-1:0] digit_segments(input logic [DIGIT_W-1:0] d);
		logic [SEG_W-1:0] seg;
		case (d)
			4'd0: seg = 8'h3F;
			4'd1: seg = 8'h06;
			4'd2: seg = 8'h5B;
			4'd3: seg = 8'h4F;
			4'd4: seg = 8'h66;
			4'd5: seg = 8'h6D;
			4'd6: seg = 8'h7D;
			4'd7: seg = 8'h07;
			4'd8: seg = 8'h7F;
			4'd9: seg = 8'h6F;
			default: seg = 8'h00;
		endcase
		return seg;
	endfunction

endpackage

### hw/rtl/voltmeter_seven_segment_scan.sv
// Channel  | Dir | Beat contents (lowest bit first)
// s_*      | in  | tuser: operation; tdata: sample, zero padded to bytes
// m_*      | out | tdata: segments[7:0], digit_enable_n[11:8], next_channel[14:12], 0
// cfg_*    | in  | cfg_addr: register index; cfg_data: value (always ready)
//
// One beat is taken every cycle while the output is not stalled.
// The pipe has six stages: sample select, multiply, divide by 2^SAMPLE_BITS-1,
// correct and saturate, then the two decimal digit splits.
// A stalled output freezes the whole pipe, and s_tready follows it.
// arst_n clears the configuration to its defaults, the stored samples and the display.
module voltmeter_seven_segment_scan #(
	parameter int CHANNELS    = 6,
	parameter int SAMPLE_BITS = 10
) (
	input  logic                                     clk,
	input  logic                                     arst_n,
	input  logic                                     s_tvalid,
	output logic                                     s_tready,
	input  logic [((SAMPLE_BITS + 7) / 8) * 8 - 1:0] s_tdata,  // sample
	input  logic                                     s_tuser,  // operation
	output logic                                     m_tvalid,
	input  logic                                     m_tready,
	output logic [vss_pkg::OUT_DATA_W-1:0]           m_tdata,  // segments, digit_enable_n,
	                                                           // next_channel
	input  logic                                     cfg_valid,
	output logic                                     cfg_ready,
	input  logic [vss_pkg::CFG_ADDR_W-1:0]           cfg_addr,
	input  logic [vss_pkg::SCALE_W-1:0]              cfg_data
);

	localparam int IDX_W  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam int PROD_W = SAMPLE_BITS + vss_pkg::SCALE_W;
	localparam int Q_W    = vss_pkg::SCALE_W + 1;
	localparam int R_W    = SAMPLE_BITS + 2;
	localparam logic [vss_pkg::CHAN_W:0] CHAN_CNT = (vss_pkg::CHAN_W + 1)'(CHANNELS);
	localparam logic [R_W-1:0] DIV_M  = R_W'((1 << SAMPLE_BITS) - 1);
	localparam logic [R_W-1:0] DIV_M2 = R_W'(2 * ((1 << SAMPLE_BITS) - 1));

	logic                                adv;
	logic                                accept;
	logic                                is_sample;

	logic [vss_pkg::REFRESH_W-1:0]       refresh_q;
	logic [vss_pkg::CHAN_W-1:0]          monitor_q;
	logic [vss_pkg::SCALE_W-1:0]         scale_q;

	logic [vss_pkg::CHAN_W-1:0]          chan_q;
	logic [1:0]                          scan_q;
	logic [vss_pkg::REFRESH_W-1:0]       tick_q;
	logic [SAMPLE_BITS-1:0]              samples_q [CHANNELS];

	logic [vss_pkg::CHAN_W-1:0]          wr_idx;
	logic [vss_pkg::CHAN_W:0]            chan_inc;
	logic [vss_pkg::CHAN_W-1:0]          chan_next;
	logic                                mon_ok;
	logic [SAMPLE_BITS-1:0]              sel;
	logic [vss_pkg::REFRESH_W-1:0]       tick_inc;
	logic                                refresh_hit;

	logic                                valid_s1, valid_s2, valid_s3, valid_s4, valid_s5;
	vss_pkg::ctl_t                       ctl_s1, ctl_s2, ctl_s3, ctl_s4, ctl_s5;
	logic [SAMPLE_BITS-1:0]              sel_s1;
	logic [PROD_W-1:0]                   prod_s2;
	logic [Q_W-1:0]                      q0_s3;
	logic [R_W-1:0]                      r_s3;
	logic [vss_pkg::VALUE_W-1:0]         value_s4;
	logic [vss_pkg::DIGIT_W-1:0]         hund_s5;
	logic [6:0]                          rem_s5;

	logic [Q_W-1:0]                      q0;
	logic [PROD_W:0]                     qm;
	logic [PROD_W:0]                     r_full;
	logic [Q_W-1:0]                      q;
	logic [15:0]                         hund_prod;
	logic [vss_pkg::DIGIT_W-1:0]         hund;
	logic [vss_pkg::VALUE_W-1:0]         hund_x;
	logic [vss_pkg::VALUE_W-1:0]         rem_full;
	logic [14:0]                         tens_prod;
	logic [vss_pkg::DIGIT_W-1:0]         tens;
	logic [6:0]                          tens_x;
	logic [6:0]                          unit_full;

	logic [vss_pkg::DIGIT_W-1:0]         hund_q, tens_q, units_q;
	logic [vss_pkg::SEG_W-1:0]           seg_q, seg_next;
	logic [vss_pkg::EN_W-1:0]            en_q, en_next;
	logic [vss_pkg::CHAN_W-1:0]          chan_out_q;

	assign adv       = !m_tvalid || m_tready;
	assign s_tready  = adv;
	assign accept    = s_tvalid && adv;
	assign is_sample = (s_tuser == vss_pkg::OP_SAMPLE);
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			refresh_q <= vss_pkg::REFRESH_RST;
			monitor_q <= vss_pkg::MONITOR_RST;
			scale_q   <= vss_pkg::SCALE_RST;
		end else if (cfg_valid) begin
			case (cfg_addr)
				vss_pkg::CFG_REFRESH:    refresh_q <= cfg_data[vss_pkg::REFRESH_W-1:0];
				vss_pkg::CFG_MONITOR:    monitor_q <= cfg_data[vss_pkg::CHAN_W-1:0];
				vss_pkg::CFG_FULL_SCALE: scale_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	always_comb begin
		wr_idx      = ({1'b0, chan_q} >= CHAN_CNT) ? '0 : chan_q;
		chan_inc    = {1'b0, wr_idx} + 1'b1;
		chan_next   = (chan_inc >= CHAN_CNT) ? '0 : chan_inc[vss_pkg::CHAN_W-1:0];
		mon_ok      = ({1'b0, monitor_q} < CHAN_CNT);
		sel         = mon_ok ? samples_q[monitor_q[IDX_W-1:0]] : '0;
		tick_inc    = tick_q + 1'b1;
		refresh_hit = (tick_inc == refresh_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chan_q <= '0;
			scan_q <= vss_pkg::SCAN_SYMBOL;
			tick_q <= '0;
			for (int i = 0; i < CHANNELS; i++) begin
				samples_q[i] <= '0;
			end
		end else if (accept) begin
			if (is_sample) begin
				samples_q[wr_idx[IDX_W-1:0]] <= s_tdata[SAMPLE_BITS-1:0];
				chan_q <= chan_next;
			end else begin
				scan_q <= scan_q + 1'b1;
				tick_q <= refresh_hit ? '0 : tick_inc;
			end
		end
	end

	// divide by 2^n-1: two shifted terms, then the remainder fixes up to two counts
	always_comb begin
		q0     = Q_W'(prod_s2 >> SAMPLE_BITS) + Q_W'(prod_s2 >> (2 * SAMPLE_BITS));
		qm     = ((PROD_W + 1)'(q0) << SAMPLE_BITS) - (PROD_W + 1)'(q0);
		r_full = {1'b0, prod_s2} - qm;
		q      = q0_s3 + Q_W'(r_s3 >= DIV_M) + Q_W'(r_s3 >= DIV_M2);
	end

	// v/100 as v*41>>12 and r/10 as r*205>>11, exact over their ranges
	always_comb begin
		hund_prod = 16'(value_s4) * 16'd41;
		hund      = hund_prod[15:12];
		hund_x    = vss_pkg::VALUE_W'(hund) * 10'd100;
		rem_full  = value_s4 - hund_x;
		tens_prod = 15'(rem_s5) * 15'd205;
		tens      = tens_prod[14:11];
		tens_x    = 7'(tens) * 7'd10;
		unit_full = rem_s5 - tens_x;
	end

	always_comb begin
		case (ctl_s5.scan)
			vss_pkg::SCAN_SYMBOL: begin
				seg_next = vss_pkg::SEG_SYMBOL_V;
				en_next  = (en_q | 4'b1000) & 4'b1110;
			end
			vss_pkg::SCAN_UNITS: begin
				seg_next = vss_pkg::digit_segments(units_q);
				en_next  = (en_q | 4'b0001) & 4'b1101;
			end
			vss_pkg::SCAN_TENS: begin
				seg_next = vss_pkg::digit_segments(tens_q);
				en_next  = (en_q | 4'b0010) & 4'b1011;
			end
			default: begin
				seg_next = vss_pkg::digit_segments(hund_q) | vss_pkg::SEG_DP;
				en_next  = (en_q | 4'b0100) & 4'b0111;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
			m_tvalid <= 1'b0;
			hund_q   <= '0;
			tens_q   <= '0;
			units_q  <= '0;
			seg_q    <= '0;
			en_q     <= '0;
			chan_out_q <= '0;
		end else if (adv) begin
			valid_s1 <= accept;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
			valid_s5 <= valid_s4;
			m_tvalid <= valid_s5;
			if (valid_s5) begin
				chan_out_q <= ctl_s5.chan;
				if (ctl_s5.op == vss_pkg::OP_TICK) begin
					seg_q <= seg_next;
					en_q  <= en_next;
				end
				if (ctl_s5.refresh) begin
					hund_q  <= hund_s5;
					tens_q  <= tens;
					units_q <= unit_full[vss_pkg::DIGIT_W-1:0];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			ctl_s1.op      <= s_tuser;
			ctl_s1.refresh <= !is_sample && refresh_hit;
			ctl_s1.scan    <= scan_q;
			ctl_s1.chan    <= is_sample ? chan_next : chan_q;
			sel_s1         <= sel;
			ctl_s2         <= ctl_s1;
			prod_s2        <= PROD_W'(sel_s1) * PROD_W'(scale_q);
			ctl_s3         <= ctl_s2;
			q0_s3          <= q0;
			r_s3           <= r_full[R_W-1:0];
			ctl_s4         <= ctl_s3;
			value_s4       <= (q > Q_W'(vss_pkg::VALUE_MAX)) ? vss_pkg::VALUE_MAX
			                                                : q[vss_pkg::VALUE_W-1:0];
			ctl_s5         <= ctl_s4;
			hund_s5        <= hund;
			rem_s5         <= rem_full[6:0];
		end
	end

	assign m_tdata = {1'b0, chan_out_q, en_q, seg_q};

endmodule

### hw/rtl/vss_check.sv
module vss_check #(
	parameter int CHANNELS = 6
) (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           s_tvalid,
	input logic                           s_tready,
	input logic                           m_tvalid,
	input logic                           m_tready,
	input logic [vss_pkg::OUT_DATA_W-1:0] m_tdata
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result beat changed while stalled");

	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid |-> s_tready)
		else $error("input refused with empty output");

	a_chan_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[14:12] < CHANNELS))
		else $error("next channel out of range");

	a_dp_on_hundreds: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[7] |-> !m_tdata[11] && !m_tdata[15])
		else $error("decimal point shown off the hundreds digit");

endmodule

bind voltmeter_seven_segment_scan vss_check #(.CHANNELS(CHANNELS)) u_vss_check (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);
